// ===== hdl/ssch_pkg.sv =====
// ----------------------------------------------------------------------------
// ssch_pkg
// Shared constants of the stride scheduler: command codes, status codes,
// job table entry states and field widths.
// ----------------------------------------------------------------------------
package ssch_pkg;

	// table size default
	localparam int MAX_JOBS_DEF = 16;

	// field widths
	localparam int FUNC_W   = 3;
	localparam int ID_W     = 4;
	localparam int PRIO_W   = 10;
	localparam int STAT_W   = 2;
	localparam int PASS_W   = 32;
	localparam int STRIDE_W = 17;

	// stride numerator and pass ceiling
	localparam logic [STRIDE_W-1:0] STRIDE_NUM = 17'd100000;
	localparam logic [PASS_W-1:0]   PASS_MAX   = 32'hFFFF_FFFF;

	// command codes
	localparam logic [FUNC_W-1:0] FN_NEW     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_FINISH  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_TICK    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_BLOCK   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_UNBLOCK = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] RS_OK          = 2'd0;
	localparam logic [STAT_W-1:0] RS_IDLE_ERR    = 2'd1;
	localparam logic [STAT_W-1:0] RS_NOT_BLOCKED = 2'd2;
	localparam logic [STAT_W-1:0] RS_ID_USED     = 2'd3;

	// job table entry states
	localparam logic [1:0] ES_EMPTY    = 2'd0;
	localparam logic [1:0] ES_RUNNABLE = 2'd1;
	localparam logic [1:0] ES_BLOCKED  = 2'd2;

endpackage

// ===== hdl/ssch_ram.sv =====
// ----------------------------------------------------------------------------
// ssch_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module ssch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/stride_scheduler.sv =====
// ----------------------------------------------------------------------------
// stride_scheduler
// Stride scheduler over a job table indexed by job id; each valid command updates
// the table, and every command reports the job that now runs.
// ----------------------------------------------------------------------------
// Usage:
//   A command (func, job_id, priority_req) is taken on a rising edge with
//   start high and busy low. Exactly one result per command comes back on
//   status / running_* with done high for one cycle; the receiver cannot
//   stall, so the result must be taken in that cycle.
//   Steps of each command after the accepting edge:
//     new job                          : stride divide, table write, result
//     unblock                          : pass read, table write, result
//     finish / block                   : least-pass search, pick, result
//     interrupt tick                   : pass increment, search, pick, result
//     rejected or unknown commands     : result only
//   The least-pass search reads the pass RAM one entry per cycle, so the
//   finish, block and tick take longer as MAX_JOBS grows. One command is in
//   flight at a time; busy drops in the cycle done is shown, so the next
//   command can be taken then.
//   Reset clears the entry states to empty and leaves the system idle; the
//   pass and stride RAMs need no clearing, an entry is used only once written.
// ----------------------------------------------------------------------------
module stride_scheduler #(
	parameter int MAX_JOBS = ssch_pkg::MAX_JOBS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [ssch_pkg::FUNC_W-1:0]   func,
	input  logic [ssch_pkg::ID_W-1:0]     job_id,
	input  logic [ssch_pkg::PRIO_W-1:0]   priority_req,
	output logic                          done,
	output logic [ssch_pkg::STAT_W-1:0]   status,
	output logic                          running_valid,
	output logic [ssch_pkg::ID_W-1:0]     running_job,
	output logic [ssch_pkg::PASS_W-1:0]   running_pass,
	output logic [ssch_pkg::STRIDE_W-1:0] running_stride
);

	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int PW    = ssch_pkg::PASS_W;
	localparam int SW    = ssch_pkg::STRIDE_W;
	localparam int DW    = ssch_pkg::PRIO_W;

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DIV      = 4'd1;
	localparam logic [3:0] S_NEW_WR   = 4'd2;
	localparam logic [3:0] S_TICK_RD  = 4'd3;
	localparam logic [3:0] S_TICK_WR  = 4'd4;
	localparam logic [3:0] S_UB_RD    = 4'd5;
	localparam logic [3:0] S_UB_WR    = 4'd6;
	localparam logic [3:0] S_SCAN     = 4'd7;
	localparam logic [3:0] S_SCAN_END = 4'd8;
	localparam logic [3:0] S_PICK     = 4'd9;
	localparam logic [3:0] S_OUT_RD   = 4'd10;
	localparam logic [3:0] S_OUT      = 4'd11;

	logic [3:0]        state_q;
	logic              done_q;
	logic              idle_q;
	logic [IDX_W-1:0]  cur_q;
	logic [1:0]        entry_st_q [MAX_JOBS];

	// command context
	logic [IDX_W-1:0]  id_q;
	logic [1:0]        cmd_stat_q;

	// stride divider
	logic [SW-1:0]     div_num_q;
	logic [DW-1:0]     div_rem_q;
	logic [DW-1:0]     div_d_q;
	logic [4:0]        div_cnt_q;
	logic [DW+1:0]     div_diff;
	logic              div_ge;

	// least-pass search
	logic [IDX_W-1:0]  scan_q;
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [PW-1:0]     best_pass_q;
	logic              take;

	// result register
	logic [1:0]        status_q;
	logic              rvalid_q;
	logic [3:0]        rjob_q;
	logic [PW-1:0]     rpass_q;
	logic [SW-1:0]     rstride_q;

	// memory ports
	logic              pass_we;
	logic [IDX_W-1:0]  pass_waddr;
	logic [PW-1:0]     pass_wdata;
	logic              pass_re;
	logic [IDX_W-1:0]  pass_raddr;
	logic [PW-1:0]     pass_rd;
	logic              stride_we;
	logic              stride_re;
	logic [SW-1:0]     stride_rd;

	logic              accept;
	logic [IDX_W-1:0]  id_idx;
	logic              id_ok;
	logic [PW:0]       tick_sum;
	logic [PW-1:0]     tick_pass;
	logic [PW-1:0]     inherit_pass;

	assign accept = start && !busy;
	assign id_idx = IDX_W'(job_id);
	assign id_ok  = 32'(job_id) < 32'(MAX_JOBS);

	// restoring divide step, one quotient bit per cycle
	assign div_diff = {1'b0, div_rem_q, div_num_q[SW-1]} - {2'b00, div_d_q};
	assign div_ge   = !div_diff[DW+1];

	// saturating pass increment
	assign tick_sum  = {1'b0, pass_rd} + {{(PW+1-SW){1'b0}}, stride_rd};
	assign tick_pass = tick_sum[PW] ? ssch_pkg::PASS_MAX : tick_sum[PW-1:0];

	// pass a new or unblocked job starts from
	assign inherit_pass = idle_q ? '0 : pass_rd;

	// candidate check for the entry whose pass just came out of the RAM
	assign take = valid_s1 && (entry_st_q[idx_s1] == ssch_pkg::ES_RUNNABLE) &&
		(!found_q || (pass_rd < best_pass_q));

	// memory port control
	always_comb begin
		pass_we    = 1'b0;
		pass_waddr = id_q;
		pass_wdata = inherit_pass;
		stride_we  = 1'b0;
		case (state_q)
			S_NEW_WR: begin
				pass_we   = 1'b1;
				stride_we = 1'b1;
			end
			S_UB_WR: begin
				pass_we = 1'b1;
			end
			S_TICK_WR: begin
				pass_we    = 1'b1;
				pass_waddr = cur_q;
				pass_wdata = tick_pass;
			end
			default: begin
				pass_we = 1'b0;
			end
		endcase
	end

	assign pass_re = (state_q == S_DIV) || (state_q == S_TICK_RD) ||
		(state_q == S_UB_RD) || (state_q == S_SCAN) || (state_q == S_OUT_RD);
	assign pass_raddr = (state_q == S_SCAN) ? scan_q : cur_q;
	assign stride_re  = (state_q == S_TICK_RD) || (state_q == S_OUT_RD);

	ssch_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_JOBS)
	) u_pass_ram (
		.clk  (clk),
		.we   (pass_we),
		.waddr(pass_waddr),
		.wdata(pass_wdata),
		.re   (pass_re),
		.raddr(pass_raddr),
		.rdata(pass_rd)
	);

	ssch_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_JOBS)
	) u_stride_ram (
		.clk  (clk),
		.we   (stride_we),
		.waddr(id_q),
		.wdata(div_num_q),
		.re   (stride_re),
		.raddr(cur_q),
		.rdata(stride_rd)
	);

	// sequencer and scheduler control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			idle_q    <= 1'b1;
			cur_q     <= '0;
			scan_q    <= '0;
			valid_s1  <= 1'b0;
			found_q   <= 1'b0;
			div_cnt_q <= '0;
			for (int i = 0; i < MAX_JOBS; i++) begin
				entry_st_q[i] <= ssch_pkg::ES_EMPTY;
			end
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= (state_q == S_SCAN);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						scan_q    <= '0;
						found_q   <= 1'b0;
						div_cnt_q <= '0;
						case (func)
							ssch_pkg::FN_NEW: begin
								if (id_ok && (entry_st_q[id_idx] == ssch_pkg::ES_EMPTY)) begin
									state_q <= S_DIV;
								end else begin
									state_q <= S_OUT_RD;
								end
							end
							ssch_pkg::FN_FINISH, ssch_pkg::FN_BLOCK: begin
								if (idle_q) begin
									state_q <= S_OUT_RD;
								end else begin
									entry_st_q[cur_q] <= (func == ssch_pkg::FN_FINISH) ?
										ssch_pkg::ES_EMPTY : ssch_pkg::ES_BLOCKED;
									state_q <= S_SCAN;
								end
							end
							ssch_pkg::FN_TICK: begin
								state_q <= idle_q ? S_OUT_RD : S_TICK_RD;
							end
							ssch_pkg::FN_UNBLOCK: begin
								if (id_ok && (entry_st_q[id_idx] == ssch_pkg::ES_BLOCKED)) begin
									state_q <= S_UB_RD;
								end else begin
									state_q <= S_OUT_RD;
								end
							end
							default: begin
								state_q <= S_OUT_RD;
							end
						endcase
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'(SW - 1)) begin
						state_q <= S_NEW_WR;
					end
				end
				S_NEW_WR, S_UB_WR: begin
					entry_st_q[id_q] <= ssch_pkg::ES_RUNNABLE;
					if (idle_q) begin
						cur_q  <= id_q;
						idle_q <= 1'b0;
					end
					state_q <= S_OUT_RD;
				end
				S_TICK_RD: begin
					state_q <= S_TICK_WR;
				end
				S_TICK_WR: begin
					state_q <= S_SCAN;
				end
				S_UB_RD: begin
					state_q <= S_UB_WR;
				end
				S_SCAN, S_SCAN_END: begin
					if (take) begin
						found_q <= 1'b1;
					end
					if (state_q == S_SCAN_END) begin
						state_q <= S_PICK;
					end else if (scan_q == IDX_W'(MAX_JOBS - 1)) begin
						state_q <= S_SCAN_END;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_PICK: begin
					cur_q   <= found_q ? best_idx_q : '0;
					idle_q  <= !found_q;
					state_q <= S_OUT_RD;
				end
				S_OUT_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q;
		if (take) begin
			best_idx_q  <= idx_s1;
			best_pass_q <= pass_rd;
		end
		// command context and divider load
		if ((state_q == S_IDLE) && accept) begin
			id_q      <= id_idx;
			div_num_q <= ssch_pkg::STRIDE_NUM;
			div_rem_q <= '0;
			div_d_q   <= (priority_req == '0) ? DW'(1) : priority_req;
			case (func)
				ssch_pkg::FN_NEW: begin
					cmd_stat_q <= (id_ok && (entry_st_q[id_idx] == ssch_pkg::ES_EMPTY)) ?
						ssch_pkg::RS_OK : ssch_pkg::RS_ID_USED;
				end
				ssch_pkg::FN_FINISH, ssch_pkg::FN_TICK, ssch_pkg::FN_BLOCK: begin
					cmd_stat_q <= idle_q ? ssch_pkg::RS_IDLE_ERR : ssch_pkg::RS_OK;
				end
				ssch_pkg::FN_UNBLOCK: begin
					cmd_stat_q <= (id_ok && (entry_st_q[id_idx] == ssch_pkg::ES_BLOCKED)) ?
						ssch_pkg::RS_OK : ssch_pkg::RS_NOT_BLOCKED;
				end
				default: begin
					cmd_stat_q <= ssch_pkg::RS_OK;
				end
			endcase
		end
		// divide step
		if (state_q == S_DIV) begin
			div_rem_q <= div_ge ? div_diff[DW-1:0] : {div_rem_q[DW-2:0], div_num_q[SW-1]};
			div_num_q <= {div_num_q[SW-2:0], div_ge};
		end
		// result capture
		if (state_q == S_OUT) begin
			status_q  <= cmd_stat_q;
			rvalid_q  <= !idle_q;
			rjob_q    <= idle_q ? 4'd0 : 4'(cur_q);
			rpass_q   <= idle_q ? '0 : pass_rd;
			rstride_q <= idle_q ? '0 : stride_rd;
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign running_valid  = rvalid_q;
	assign running_job    = rjob_q;
	assign running_pass   = rpass_q;
	assign running_stride = rstride_q;

endmodule

// ===== hdl/ssch_chk.sv =====
// ----------------------------------------------------------------------------
// ssch_chk
// Port-level checks of the stride scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ssch_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [ssch_pkg::FUNC_W-1:0]   func,
	input logic [ssch_pkg::ID_W-1:0]     job_id,
	input logic [ssch_pkg::PRIO_W-1:0]   priority_req,
	input logic                          done,
	input logic [ssch_pkg::STAT_W-1:0]   status,
	input logic                          running_valid,
	input logic [ssch_pkg::ID_W-1:0]     running_job,
	input logic [ssch_pkg::PASS_W-1:0]   running_pass,
	input logic [ssch_pkg::STRIDE_W-1:0] running_stride
);

	// a taken request keeps the block busy and gives no result the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("request taken but block not busy");

	// the result strobe is a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// a result is shown only when the block is free again
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an idle system reports an all-zero running job
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !running_valid) |->
		(running_job == '0 && running_pass == '0 && running_stride == '0))
		else $error("idle result with nonzero job fields");

	// an idle error means no job is running
	a_idle_err: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ssch_pkg::RS_IDLE_ERR) |-> !running_valid)
		else $error("idle error reported with a running job");

endmodule

bind stride_scheduler ssch_chk u_ssch_chk (.*);
